// ===== sv/polyphonic_sine_synth_defines.svh =====
// assertion macros for the polyphonic sine synth checker
// no dependencies; included by the checker file
`ifndef POLYPHONIC_SINE_SYNTH_DEFINES_SVH
`define POLYPHONIC_SINE_SYNTH_DEFINES_SVH

// implication checked in the next cycle, masked during reset
`define PSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// implication checked in the next cycle, active during reset too
`define PSS_ASSERT_NEXT_ALWAYS(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pss_pkg.sv =====
// shared types, constants and elaboration-time tables for the sine synth
// no dependencies
package pss_pkg;

  localparam int VOICES      = 8;
  localparam int SAMPLE_RATE = 48000;
  localparam int SINE_DEPTH  = 1024;
  localparam int SINE_AW     = $clog2(SINE_DEPTH);
  localparam int VIDX_W      = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int ACC_W       = $clog2(VOICES + 1) + 17;

  localparam logic [1:0] MODE_TICK    = 2'd0;
  localparam logic [1:0] MODE_NOTE_ON = 2'd1;
  localparam logic [1:0] MODE_NOTE_OFF = 2'd2;
  localparam logic [1:0] MODE_ALL_OFF = 2'd3;

  localparam logic [15:0] VEL_MIN     = 16'd1311;
  localparam logic [15:0] VEL_MAX     = 16'd11796;
  localparam logic [15:0] RISE_STEP   = 16'd262;
  localparam logic [15:0] RELEASE_MUL = 16'd65208;
  localparam logic [15:0] LEVEL_FLOOR = 16'd7;
  localparam logic [15:0] DIV5_RECIP  = 16'd52429;

  typedef struct packed {
    logic        active;
    logic        releasing;
    logic [6:0]  note;
    logic [31:0] phase;
    logic [15:0] level;
    logic [15:0] target;
  } voice_t;

  typedef struct packed {
    logic shift;
    logic load;
    logic rel;
  } cell_ctl_t;

  typedef logic signed [15:0] sine_tab_t [SINE_DEPTH];
  typedef logic [31:0] step_tab_t [128];

  // sine entry by integer taylor series on the folded quarter wave
  function automatic logic signed [15:0] sine_entry(int idx);
    longint unsigned one_q30;
    longint unsigned quad;
    longint unsigned r;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned h;
    longint unsigned s;
    longint unsigned q;
    one_q30 = 64'd1073741824;
    quad = longint'(idx) >> (SINE_AW - 2);
    r = (longint'(idx) & ((SINE_DEPTH / 4) - 1)) << (30 - (SINE_AW - 2));
    if (quad[0]) r = one_q30 - r;
    x  = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    h  = one_q30 - x2 / 110;
    h  = one_q30 - ((x2 * h) >> 30) / 72;
    h  = one_q30 - ((x2 * h) >> 30) / 42;
    h  = one_q30 - ((x2 * h) >> 30) / 20;
    h  = one_q30 - ((x2 * h) >> 30) / 6;
    s  = (x * h) >> 30;
    q  = (s + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return (quad >= 2) ? -16'(q) : 16'(q);
  endfunction

  function automatic sine_tab_t build_sine();
    sine_tab_t tab;
    for (int i = 0; i < SINE_DEPTH; i++) tab[i] = sine_entry(i);
    return tab;
  endfunction

  // phase increment per midi note
  function automatic step_tab_t build_steps();
    longint unsigned semi [12];
    step_tab_t tab;
    longint unsigned num;
    int d;
    int sh;
    semi[0] = 16777216;  semi[1] = 17774841;  semi[2] = 18831788;
    semi[3] = 19951585;  semi[4] = 21137968;  semi[5] = 22394897;
    semi[6] = 23726566;  semi[7] = 25137421;  semi[8] = 26632170;
    semi[9] = 28215802;  semi[10] = 29893600; semi[11] = 31671166;
    for (int n = 0; n < 128; n++) begin
      d = n + 3;
      sh = d / 12 + 2;
      num = 64'd440 * semi[d % 12];
      tab[n] = 32'(((num << sh) + SAMPLE_RATE / 2) / SAMPLE_RATE);
    end
    return tab;
  endfunction

endpackage

// ===== sv/polyphonic_sine_synth.sv =====
// Polyphonic sine synth top level: a ring of VOICES voice cells rotates past one
// shared voice update stage, a sine rom and a scale multiplier. Note on, note off
// and all notes off items are taken in the idle state and leave the block idle.
// A sample tick item is accepted in the idle state, then the ring turns once
// through the update stage, one voice per cycle; the D1 and D2 states drain
// the rom and multiplier stages, and the FIN state places the saturated sum in
// the output register. The next item is accepted while a finished sample waits
// to be taken; a tick only holds in FIN while the previous sample is not taken.
// depends on pss_pkg, pss_cell, pss_sine_rom
module polyphonic_sine_synth
  import pss_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_mode,
  input  logic [6:0]         in_note,
  input  logic [15:0]        in_velocity,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [16:0] out_mixed_sample
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_RUN  = 3'd1;
  localparam logic [2:0] ST_D1   = 3'd2;
  localparam logic [2:0] ST_D2   = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  localparam step_tab_t STEP_TAB = build_steps();

  logic [2:0]              state_r, state_nxt;
  logic [VIDX_W-1:0]       cnt_r, cnt_nxt;
  logic                    s1_v_r, s1_v_nxt;
  logic [15:0]             s1_level_r;
  logic signed [16:0]      s2_r, s2_nxt;
  logic signed [ACC_W-1:0] acc_r, acc_nxt;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [16:0]      out_r;
  logic                    fin_load;

  voice_t    cell_q   [VOICES];
  cell_ctl_t cell_ctl [VOICES];
  voice_t    head_nxt;

  logic              accept;
  logic              tick_acc;
  logic [VOICES-1:0] match_v;
  logic [VOICES-1:0] pick_v;
  logic [15:0]       vel_c;
  logic [31:0]       tgt_prod;
  logic [15:0]       load_target;

  logic              contrib;
  logic [31:0]       rel_prod;
  logic [16:0]       rise_up;
  logic [15:0]       new_level;
  logic signed [15:0] sine_q;
  logic [15:0]       sine_abs;
  logic [31:0]       mag_prod;
  logic [15:0]       mag;

  assign accept   = in_valid && !in_stall;
  assign tick_acc = accept && (in_mode == MODE_TICK);
  assign in_stall = (state_r != ST_IDLE);

  // note-on voice choice: first matching active voice, else first free, else 0
  always_comb begin
    logic found;
    found = 1'b0;
    pick_v = '0;
    for (int i = 0; i < VOICES; i++) begin
      match_v[i] = cell_q[i].active && (cell_q[i].note == in_note);
    end
    for (int i = 0; i < VOICES; i++) begin
      if (!found && match_v[i]) begin
        pick_v[i] = 1'b1;
        found = 1'b1;
      end
    end
    for (int i = 0; i < VOICES; i++) begin
      if (!found && !cell_q[i].active) begin
        pick_v[i] = 1'b1;
        found = 1'b1;
      end
    end
    if (!found) pick_v[0] = 1'b1;
  end

  // target = round(clamp(velocity) * 0.8), divide by five via reciprocal
  always_comb begin
    logic [15:0] num;
    vel_c = in_velocity;
    if (vel_c < VEL_MIN) vel_c = VEL_MIN;
    if (vel_c > VEL_MAX) vel_c = VEL_MAX;
    num = {vel_c[13:0], 2'b00} + 16'd2;
    tgt_prod = num * DIV5_RECIP;
    load_target = 16'(tgt_prod >> 18);
  end

  // per-cell commands
  always_comb begin
    for (int i = 0; i < VOICES; i++) begin
      cell_ctl[i].shift = (state_r == ST_RUN);
      cell_ctl[i].load  = accept && (in_mode == MODE_NOTE_ON) && pick_v[i];
      cell_ctl[i].rel   = accept && ((in_mode == MODE_ALL_OFF) ||
                          ((in_mode == MODE_NOTE_OFF) && match_v[i]));
    end
  end

  // voice update at the head of the ring
  always_comb begin
    head_nxt  = cell_q[0];
    contrib   = 1'b0;
    rel_prod  = cell_q[0].level * RELEASE_MUL;
    rise_up   = {1'b0, cell_q[0].level} + {1'b0, RISE_STEP};
    new_level = cell_q[0].level;
    if (cell_q[0].active) begin
      if (cell_q[0].releasing) begin
        new_level = rel_prod[31:16];
        contrib = (new_level >= LEVEL_FLOOR);
      end else begin
        new_level = (rise_up < {1'b0, cell_q[0].target}) ? rise_up[15:0]
                                                           : cell_q[0].target;
        contrib = 1'b1;
      end
      head_nxt.level  = new_level;
      head_nxt.active = contrib;
      if (contrib) head_nxt.phase = cell_q[0].phase + STEP_TAB[cell_q[0].note];
    end
  end

  // ring of voice cells
  for (genvar g = 0; g < VOICES; g++) begin : g_cell
    voice_t sin_w;
    if (g == VOICES - 1) begin : g_tail
      assign sin_w = head_nxt;
    end else begin : g_mid
      assign sin_w = cell_q[g+1];
    end
    pss_cell u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctl         (cell_ctl[g]),
      .shift_in    (sin_w),
      .load_note   (in_note),
      .load_target (load_target),
      .voice_q     (cell_q[g])
    );
  end

  pss_sine_rom u_rom (
    .clk     (clk),
    .addr    (cell_q[0].phase[31 -: SINE_AW]),
    .rd_data (sine_q)
  );

  // scale sine by level, rounded
  always_comb begin
    sine_abs = sine_q[15] ? 16'(-sine_q) : 16'(sine_q);
    mag_prod = sine_abs * s1_level_r + 32'd32768;
    mag      = mag_prod[31:16];
    s2_nxt   = '0;
    if (s1_v_r) s2_nxt = sine_q[15] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  end

  assign s1_v_nxt = (state_r == ST_RUN) && contrib;
  assign acc_nxt  = tick_acc ? '0 : acc_r + ACC_W'(s2_r);
  assign fin_load = (state_r == ST_FIN) && (!out_valid_r || !out_stall);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (tick_acc) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == VIDX_W'(VOICES - 1)) state_nxt = ST_D1;
      end
      ST_D1:   state_nxt = ST_D2;
      ST_D2:   state_nxt = ST_FIN;
      ST_FIN:  if (fin_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fin_load) out_valid_nxt = 1'b1;
    else if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      s1_v_r      <= 1'b0;
      s2_r        <= '0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      s1_v_r      <= s1_v_nxt;
      s2_r        <= s2_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers with saturation of the mix
  always_ff @(posedge clk) begin
    s1_level_r <= new_level;
    if (fin_load) begin
      if (acc_r > ACC_W'(65535)) out_r <= 17'sd65535;
      else if (acc_r < -ACC_W'(65536)) out_r <= -17'sd65536;
      else out_r <= 17'(acc_r);
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mixed_sample = out_r;

endmodule

// ===== sv/pss_cell.sv =====
// one voice cell of the rotating voice chain
// depends on pss_pkg
module pss_cell
  import pss_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cell_ctl_t   ctl,
  input  voice_t      shift_in,
  input  logic [6:0]  load_note,
  input  logic [15:0] load_target,
  output voice_t      voice_q
);

  voice_t voice_r;
  voice_t voice_nxt;

  // rotate on tick, otherwise apply note commands
  always_comb begin
    voice_nxt = voice_r;
    if (ctl.shift) begin
      voice_nxt = shift_in;
    end else if (ctl.load) begin
      voice_nxt.active    = 1'b1;
      voice_nxt.releasing = 1'b0;
      voice_nxt.note      = load_note;
      voice_nxt.phase     = '0;
      voice_nxt.level     = '0;
      voice_nxt.target    = load_target;
    end else if (ctl.rel) begin
      voice_nxt.releasing = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      voice_r.active    <= 1'b0;
      voice_r.releasing <= 1'b0;
      voice_r.note      <= '0;
      voice_r.phase     <= '0;
      voice_r.level     <= '0;
      voice_r.target    <= '0;
    end else begin
      voice_r <= voice_nxt;
    end
  end

  assign voice_q = voice_r;

endmodule

// ===== sv/pss_sine_rom.sv =====
// sine rom with registered read, contents built at elaboration
// depends on pss_pkg
module pss_sine_rom
  import pss_pkg::*;
(
  input  logic                      clk,
  input  logic [SINE_AW-1:0]        addr,
  output logic signed [15:0]        rd_data
);

  localparam sine_tab_t SINE_TAB = build_sine();

  always_ff @(posedge clk) begin
    rd_data <= SINE_TAB[addr];
  end

endmodule

// ===== sv/pss_checker.sv =====
// port-level checker for the polyphonic sine synth, bound to the top level
// depends on pss_pkg and polyphonic_sine_synth_defines.svh
`include "polyphonic_sine_synth_defines.svh"

module pss_checker
  import pss_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic [1:0]         in_mode,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [16:0] out_mixed_sample
);

  // a waiting sample stays and holds its value
  `PSS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid, "sample dropped")
  `PSS_ASSERT_NEXT(a_out_stable, out_valid && out_stall, $stable(out_mixed_sample), "sample changed")
  // a tick item keeps the block busy the next cycle
  `PSS_ASSERT_NEXT(a_tick_busy, in_valid && !in_stall && in_mode == MODE_TICK, in_stall, "tick not busy")
  // note commands leave the block ready in the next cycle
  `PSS_ASSERT_NEXT(a_cmd_fast, in_valid && !in_stall && in_mode != MODE_TICK, !in_stall, "command stalled")
  // reset clears the output
  `PSS_ASSERT_NEXT_ALWAYS(a_rst_out, !rst_n, !out_valid, "output valid after reset")

endmodule

bind polyphonic_sine_synth pss_checker u_pss_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .in_mode          (in_mode),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_mixed_sample (out_mixed_sample)
);

// ===== dv/polyphonic_sine_synth_tb.sv =====
// self-checking testbench for the polyphonic sine synth: directed table, then random items
// carries its own voice predictor for the mixed sample; depends on pss_pkg and the synth top
module polyphonic_sine_synth_tb;
  import pss_pkg::*;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_mode = MODE_TICK;
  logic [6:0]         in_note = '0;
  logic [15:0]        in_velocity = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [16:0] out_mixed_sample;

  polyphonic_sine_synth DUT (.*);

  initial begin
    forever #1 clk = ~clk;
  end

  // predictor voice state
  logic        v_active [VOICES];
  logic        v_rel    [VOICES];
  logic [6:0]  v_note   [VOICES];
  logic [31:0] v_phase  [VOICES];
  logic [15:0] v_level  [VOICES];
  logic [15:0] v_target [VOICES];

  logic signed [16:0] expected_samples [$];
  int mismatches = 0;
  int samples_seen = 0;
  int items_sent = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_len = 0;
  int quiet_cycles = 0;

  // sine sample in q1.15 from the top ten phase bits, folded quarter wave
  function automatic int sine_of_phase(logic [31:0] ph);
    longint unsigned one, r, x, x2, h, s, q;
    logic [9:0] ix;
    ix = ph[31:22];
    one = 64'd1 << 30;
    r = longint'(ix[7:0]) << 22;
    if (ix[8]) r = one - r;
    x  = (r * 64'd1686629713) >> 30;
    x2 = (x * x) >> 30;
    h  = one - x2 / 110;
    h  = one - ((x2 * h) >> 30) / 72;
    h  = one - ((x2 * h) >> 30) / 42;
    h  = one - ((x2 * h) >> 30) / 20;
    h  = one - ((x2 * h) >> 30) / 6;
    s  = (x * h) >> 30;
    q  = (s + 64'd16384) >> 15;
    if (q > 64'd32767) q = 64'd32767;
    return ix[9] ? -int'(q) : int'(q);
  endfunction

  // phase increment for one midi note
  function automatic logic [31:0] phase_step_for(logic [6:0] n);
    longint unsigned ratio [12];
    longint unsigned num;
    int d;
    ratio = '{16777216, 17774841, 18831788, 19951585, 21137968, 22394897,
              23726566, 25137421, 26632170, 28215802, 29893600, 31671166};
    d = int'(n) + 3;
    num = 64'd440 * ratio[d % 12];
    return 32'(((num << (d / 12 + 2)) + SAMPLE_RATE / 2) / SAMPLE_RATE);
  endfunction

  task automatic clear_voices();
    for (int i = 0; i < VOICES; i++) begin
      v_active[i] = 1'b0; v_rel[i] = 1'b0; v_note[i] = '0;
      v_phase[i] = '0; v_level[i] = '0; v_target[i] = '0;
    end
  endtask

  // apply one accepted item to the voices; returns 1 with the mix on a tick
  function automatic bit advance_voices(logic [1:0] m, logic [6:0] n, logic [15:0] vel,
                                        output logic signed [16:0] mix);
    int pick;
    longint sum;
    longint unsigned mag;
    int sv;
    logic [16:0] up;
    logic [15:0] vc;
    mix = '0;
    case (m)
      MODE_NOTE_ON: begin
        pick = -1;
        for (int i = 0; i < VOICES; i++)
          if (pick < 0 && v_active[i] && v_note[i] == n) pick = i;
        for (int i = 0; i < VOICES; i++)
          if (pick < 0 && !v_active[i]) pick = i;
        if (pick < 0) pick = 0;
        vc = (vel < VEL_MIN) ? VEL_MIN : (vel > VEL_MAX) ? VEL_MAX : vel;
        v_note[pick] = n;
        v_phase[pick] = '0;
        v_level[pick] = '0;
        v_target[pick] = 16'((32'(vc) * 4 + 2) / 5);
        v_active[pick] = 1'b1;
        v_rel[pick] = 1'b0;
        return 0;
      end
      MODE_NOTE_OFF: begin
        for (int i = 0; i < VOICES; i++)
          if (v_active[i] && v_note[i] == n) v_rel[i] = 1'b1;
        return 0;
      end
      MODE_ALL_OFF: begin
        for (int i = 0; i < VOICES; i++) v_rel[i] = 1'b1;
        return 0;
      end
      default: begin
        sum = 0;
        for (int i = 0; i < VOICES; i++) begin
          if (v_active[i]) begin
            if (v_rel[i]) begin
              v_level[i] = 16'((32'(v_level[i]) * RELEASE_MUL) >> 16);
            end else begin
              up = 17'(v_level[i]) + RISE_STEP;
              v_level[i] = (up < 17'(v_target[i])) ? up[15:0] : v_target[i];
            end
            // a released voice that falls under the floor goes silent at once
            if (v_rel[i] && v_level[i] < LEVEL_FLOOR) begin
              v_active[i] = 1'b0;
            end else begin
              sv = sine_of_phase(v_phase[i]);
              mag = (longint'(sv < 0 ? -sv : sv) * v_level[i] + 32768) >> 16;
              sum += (sv < 0) ? -longint'(mag) : longint'(mag);
              v_phase[i] = v_phase[i] + phase_step_for(v_note[i]);
            end
          end
        end
        if (sum > 65535) sum = 65535;
        if (sum < -65536) sum = -65536;
        mix = 17'(sum);
        return 1;
      end
    endcase
  endfunction

  // offer one item, wait for acceptance, then predict
  task automatic send_item(logic [1:0] m, logic [6:0] n, logic [15:0] vel,
                           bit typed, logic signed [16:0] typed_mix);
    logic signed [16:0] mix;
    in_valid <= 1'b1;
    in_mode <= m;
    in_note <= n;
    in_velocity <= vel;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    if (advance_voices(m, n, vel, mix)) expected_samples.push_back(typed ? typed_mix : mix);
    items_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_samples.size() != 0) @(posedge clk);
  endtask

  task automatic random_items(int count);
    logic [1:0] m;
    logic [6:0] n;
    logic [15:0] vel;
    int pick;
    for (int k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      m = (pick < 60) ? MODE_TICK : (pick < 82) ? MODE_NOTE_ON :
          (pick < 97) ? MODE_NOTE_OFF : MODE_ALL_OFF;
      // a small note pool makes retriggers and note-off matches common
      n = ($urandom_range(3) == 0) ? 7'($urandom) : 7'(60 + $urandom_range(9));
      case ($urandom_range(5))
        0: vel = 16'hffff;
        1: vel = 16'h0000;
        default: vel = 16'($urandom);
      endcase
      send_item(m, n, vel, 1'b0, '0);
    end
  endtask

  // result side: check samples, random stall, long hold-off on request
  always @(posedge clk) begin
    if (out_valid && !out_stall) begin
      samples_seen++;
      if (expected_samples.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected sample %0d", out_mixed_sample);
      end else begin
        if (out_mixed_sample !== expected_samples[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("sample mismatch: expected %0d actual %0d",
                     expected_samples[0], out_mixed_sample);
        end
        void'(expected_samples.pop_front());
      end
    end
    if (hold_len > 0) begin
      out_stall <= 1'b1;
      hold_len <= hold_len - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n)
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 20000) begin
      $display("polyphonic_sine_synth: mismatch");
      $finish;
    end
  end

  typedef struct {
    logic [1:0]         m;
    logic [6:0]         n;
    logic [15:0]        vel;
    bit                 typed;
    logic signed [16:0] mix;
  } stim_row_t;

  // directed rows; zero samples are typed where phase or level is still zero
  stim_row_t directed [25] = '{
    '{MODE_TICK,     7'd0,   16'd0,     1, 17'sd0},
    '{MODE_NOTE_ON,  7'd69,  16'd0,     0, 17'sd0},
    '{MODE_TICK,     7'd0,   16'd0,     1, 17'sd0},
    '{MODE_NOTE_ON,  7'd127, 16'hffff,  0, 17'sd0},
    '{MODE_NOTE_ON,  7'd0,   16'd1311,  0, 17'sd0},
    '{MODE_TICK,     7'd127, 16'hffff,  0, 17'sd0},
    '{MODE_TICK,     7'd0,   16'd0,     0, 17'sd0},
    '{MODE_NOTE_ON,  7'd69,  16'd11796, 0, 17'sd0},
    '{MODE_NOTE_OFF, 7'd69,  16'd0,     0, 17'sd0},
    '{MODE_NOTE_OFF, 7'd5,   16'd0,     0, 17'sd0},
    '{MODE_TICK,     7'd0,   16'd0,     0, 17'sd0},
    '{MODE_NOTE_ON,  7'd40,  16'd9000,  0, 17'sd0},
    '{MODE_NOTE_ON,  7'd52,  16'hffff,  0, 17'sd0},
    '{MODE_NOTE_ON,  7'd64,  16'hffff,  0, 17'sd0},
    '{MODE_NOTE_ON,  7'd76,  16'hffff,  0, 17'sd0},
    '{MODE_NOTE_ON,  7'd88,  16'hffff,  0, 17'sd0},
    '{MODE_NOTE_ON,  7'd100, 16'hffff,  0, 17'sd0},
    '{MODE_NOTE_ON,  7'd110, 16'h5555,  0, 17'sd0},
    '{MODE_TICK,     7'd0,   16'd0,     0, 17'sd0},
    '{MODE_ALL_OFF,  7'd0,   16'd0,     0, 17'sd0},
    '{MODE_TICK,     7'd0,   16'd0,     0, 17'sd0},
    '{MODE_NOTE_ON,  7'd33,  16'haaaa,  0, 17'sd0},
    '{MODE_NOTE_OFF, 7'd33,  16'd0,     0, 17'sd0},
    '{MODE_TICK,     7'd0,   16'd0,     0, 17'sd0},
    '{MODE_TICK,     7'd0,   16'd0,     0, 17'sd0}
  };

  initial begin
    clear_voices();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed[i])
      send_item(directed[i].m, directed[i].n, directed[i].vel, directed[i].typed,
                directed[i].mix);
    wait_drained();

    // sender sparse, receiver busy; one long hold-off fills the block
    send_idle_pct = 25;
    recv_idle_pct = 52;
    random_items(250);
    hold_len <= 400;
    random_items(310);
    wait_drained();

    send_idle_pct = 52;
    recv_idle_pct = 25;
    random_items(560);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    random_items(560);
    wait_drained();
    repeat (30) @(posedge clk);

    $display("covered %0d items and %0d samples: retrigger, voice steal, release to silence,",
             items_sent, samples_seen);
    $display("random stalls on both sides and a long result hold-off");
    if (mismatches == 0 && expected_samples.size() == 0) begin
      $display("polyphonic_sine_synth: match");
    end else begin
      $display("polyphonic_sine_synth: mismatch");
    end
    $finish;
  end

endmodule

// ===== polyphonic_sine_synth.f =====
+incdir+sv
sv/pss_pkg.sv
sv/pss_cell.sv
sv/pss_sine_rom.sv
sv/polyphonic_sine_synth.sv
sv/pss_checker.sv
dv/polyphonic_sine_synth_tb.sv
